// ----- rtl/prefix_tree_bit_decoder_core_assert.svh -----
// Assertion macros used by the prefix tree decoder datapath
`ifndef PREFIX_TREE_BIT_DECODER_CORE_ASSERT_SVH
`define PREFIX_TREE_BIT_DECODER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check that cons holds in the same cycle as ante
`define PTBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check that cons holds in the cycle after ante
`define PTBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PTBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PTBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/ptbd_pkg.sv -----
// Shared types, widths and codes of the prefix tree bit decoder
package ptbd_pkg;

  localparam int IDX_W   = 9;
  localparam int SYM_W   = 8;
  localparam int CODE_W  = 8;
  localparam int NBITS_W = 4;
  localparam int NODE_W  = 2 * IDX_W + 1 + SYM_W;

  localparam int NODE_COUNT_DEF   = 512;
  localparam int SYMBOL_COUNT_DEF = 256;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_DECODE  = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr;       // write the request's node into the table
    logic restart;  // put the walk back at the root
    logic ld;       // load a code byte and fetch the current node
    logic step;     // consume one code bit and fetch the child
    logic leaf;     // take the leaf symbol and fetch the root
    logic flush;    // send the held symbol out as the last one
  } ptbd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic nbits_zero;  // incoming decode request has no valid bits
    logic bits_zero;   // no code bits left in the current byte
    logic leaf_hit;    // node just reached by a move is a leaf
    logic pend_valid;  // a decoded symbol waits for its last flag
    logic out_free;    // output register can take a symbol now
  } ptbd_sts_t;

endpackage

// ----- rtl/ptbd_ctrl.sv -----
// Controller state machine of the prefix tree bit decoder
module ptbd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_opcode,
  input  ptbd_pkg::ptbd_sts_t   sts_i,
  output ptbd_pkg::ptbd_cmd_t   cmd_o
);
  import ptbd_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_opcode)
            OP_WRITE:   cmd_o.wr = 1'b1;
            OP_RESTART: cmd_o.restart = 1'b1;
            OP_DECODE: begin
              if (!sts_i.nbits_zero) begin
                cmd_o.ld  = 1'b1;
                state_nxt = ST_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (sts_i.leaf_hit) begin
          // hold until the previous symbol has room to leave
          if (sts_i.out_free || !sts_i.pend_valid) begin
            cmd_o.leaf = 1'b1;
            if (sts_i.bits_zero) begin
              state_nxt = ST_FLUSH;
            end
          end
        end else if (!sts_i.bits_zero) begin
          cmd_o.step = 1'b1;
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!sts_i.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/ptbd_datapath.sv -----
// Node table, walk registers and output register of the prefix tree decoder
`include "prefix_tree_bit_decoder_core_assert.svh"
module ptbd_datapath #(
  parameter int NODE_COUNT   = ptbd_pkg::NODE_COUNT_DEF,
  parameter int SYMBOL_COUNT = ptbd_pkg::SYMBOL_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ptbd_pkg::IDX_W-1:0]    cfg_root,
  input  logic [ptbd_pkg::IDX_W-1:0]    in_node_index,
  input  logic [ptbd_pkg::IDX_W-1:0]    in_left_child,
  input  logic [ptbd_pkg::IDX_W-1:0]    in_right_child,
  input  logic                          in_is_leaf,
  input  logic [ptbd_pkg::SYM_W-1:0]    in_leaf_symbol,
  input  logic [ptbd_pkg::CODE_W-1:0]   in_code_byte,
  input  logic [ptbd_pkg::NBITS_W-1:0]  in_valid_bits,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ptbd_pkg::SYM_W-1:0]    out_symbol,
  output logic                          out_last,
  input  ptbd_pkg::ptbd_cmd_t           cmd_i,
  output ptbd_pkg::ptbd_sts_t           sts_o
);
  import ptbd_pkg::*;

  localparam int AW = $clog2(NODE_COUNT);
  localparam logic [NBITS_W-1:0] MAX_BITS = NBITS_W'(CODE_W);

  logic [NODE_W-1:0]  mem [NODE_COUNT];
  logic [NODE_W-1:0]  rd_data_r;
  logic               rd_oob_r;
  logic [IDX_W-1:0]   walk_r, walk_nxt;
  logic [CODE_W-1:0]  code_r;
  logic [NBITS_W-1:0] bits_r;
  logic               chk_r, chk_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  logic [SYM_W-1:0]   pend_sym_r;
  logic               out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]   out_symbol_r;
  logic               out_last_r;

  logic [NODE_W-1:0]  node_cur;
  logic [IDX_W-1:0]   node_left, node_right, child;
  logic               node_leaf;
  logic [SYM_W-1:0]   node_sym;
  logic [IDX_W-1:0]   rd_idx;
  logic               rd_en;
  logic               wr_in_range, rd_in_range;
  logic [SYM_W-1:0]   wr_sym;
  logic [NBITS_W-1:0] nbits_sat;
  logic               out_load;

  // Decode the node last read; out-of-range reads see an empty internal node
  assign node_cur   = rd_oob_r ? '0 : rd_data_r;
  assign node_left  = node_cur[NODE_W-1 -: IDX_W];
  assign node_right = node_cur[SYM_W+1 +: IDX_W];
  assign node_leaf  = node_cur[SYM_W];
  assign node_sym   = node_cur[SYM_W-1:0];
  assign child      = code_r[CODE_W-1] ? node_right : node_left;

  // Saturate the incoming fields
  assign nbits_sat   = (in_valid_bits > MAX_BITS) ? MAX_BITS : in_valid_bits;
  assign wr_sym      = ({1'b0, in_leaf_symbol} >= (SYM_W+1)'(SYMBOL_COUNT)) ?
                       SYM_W'(SYMBOL_COUNT - 1) : in_leaf_symbol;
  assign wr_in_range = ({1'b0, in_node_index} < (IDX_W+1)'(NODE_COUNT));

  // Pick the table read address for this cycle
  always_comb begin
    rd_en  = cmd_i.ld | cmd_i.step | cmd_i.leaf;
    rd_idx = walk_r;
    if (cmd_i.step) begin
      rd_idx = child;
    end else if (cmd_i.leaf) begin
      rd_idx = cfg_root;
    end
  end
  assign rd_in_range = ({1'b0, rd_idx} < (IDX_W+1)'(NODE_COUNT));

  // Node table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd_i.wr && wr_in_range) begin
      mem[in_node_index[AW-1:0]] <= {in_left_child, in_right_child, in_is_leaf, wr_sym};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx[AW-1:0]];
      rd_oob_r  <= !rd_in_range;
    end
  end

  // Walk position, leaf check flag and held symbol
  always_comb begin
    walk_nxt       = walk_r;
    chk_nxt        = chk_r;
    pend_valid_nxt = pend_valid_r;
    if (cmd_i.restart) begin
      walk_nxt = cfg_root;
    end
    if (cmd_i.ld) begin
      chk_nxt = 1'b0;
    end
    if (cmd_i.step) begin
      walk_nxt = child;
      chk_nxt  = 1'b1;
    end
    if (cmd_i.leaf) begin
      walk_nxt       = cfg_root;
      chk_nxt        = 1'b0;
      pend_valid_nxt = 1'b1;
    end
    if (cmd_i.flush) begin
      pend_valid_nxt = 1'b0;
    end
  end

  // Move a symbol into the output register, else drain it when taken
  assign out_load = cmd_i.flush | (cmd_i.leaf & pend_valid_r);
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r       <= '0;
      chk_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      walk_r       <= walk_nxt;
      chk_r        <= chk_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd_i.ld) begin
      code_r <= in_code_byte;
      bits_r <= nbits_sat;
    end else if (cmd_i.step) begin
      code_r <= {code_r[CODE_W-2:0], 1'b0};
      bits_r <= bits_r - 1'b1;
    end
    if (cmd_i.leaf) begin
      pend_sym_r <= node_sym;
    end
    if (out_load) begin
      out_symbol_r <= pend_sym_r;
      out_last_r   <= cmd_i.flush;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

  assign sts_o.nbits_zero = (nbits_sat == '0);
  assign sts_o.bits_zero  = (bits_r == '0);
  assign sts_o.leaf_hit   = chk_r & node_leaf;
  assign sts_o.pend_valid = pend_valid_r;
  assign sts_o.out_free   = !out_valid_r | out_ready;

  `PTBD_ASSERT_IMP(a_no_overwrite, clk, rst_n, out_valid_r && !out_ready, !out_load, "output register overwritten while stalled")
  `PTBD_ASSERT_IMP(a_flush_pending, clk, rst_n, cmd_i.flush, pend_valid_r, "flush without a held symbol")
  `PTBD_ASSERT_IMP(a_step_bits, clk, rst_n, cmd_i.step, bits_r != '0, "step with no code bits left")
  `PTBD_ASSERT_IMP(a_load_clean, clk, rst_n, cmd_i.ld, !pend_valid_r, "new code byte while a symbol is held")
  `PTBD_ASSERT_NXT(a_leaf_root, clk, rst_n, cmd_i.leaf, walk_r == $past(cfg_root), "walk not back at root after leaf")

endmodule

// ----- rtl/prefix_tree_bit_decoder_core.sv -----
// Top level of the prefix tree bit decoder: root register, controller, datapath
// Write, restart and zero-bit decode requests are taken in the idle state. A decode of
// n bits walks the tree with one table read per bit and per symbol; output stalls
// can hold the walk. One request at a time; the last result waits in the output
// register while the next enters.
// Reset clears walk position, root (0) and control state, but not the node table.
module prefix_tree_bit_decoder_core #(
  parameter int NODE_COUNT   = ptbd_pkg::NODE_COUNT_DEF,
  parameter int SYMBOL_COUNT = ptbd_pkg::SYMBOL_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ptbd_pkg::IDX_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_opcode,
  input  logic [ptbd_pkg::IDX_W-1:0]    in_node_index,
  input  logic [ptbd_pkg::IDX_W-1:0]    in_left_child,
  input  logic [ptbd_pkg::IDX_W-1:0]    in_right_child,
  input  logic                          in_is_leaf,
  input  logic [ptbd_pkg::SYM_W-1:0]    in_leaf_symbol,
  input  logic [ptbd_pkg::CODE_W-1:0]   in_code_byte,
  input  logic [ptbd_pkg::NBITS_W-1:0]  in_valid_bits,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ptbd_pkg::SYM_W-1:0]    out_symbol,
  output logic                          out_last
);
  import ptbd_pkg::*;

  logic [IDX_W-1:0] root_r;
  ptbd_cmd_t        cmd;
  ptbd_sts_t        sts;

  // Root register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
    end else if (cfg_wr_en) begin
      root_r <= cfg_wr_data;
    end
  end

  ptbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ptbd_datapath #(
    .NODE_COUNT   (NODE_COUNT),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_root       (root_r),
    .in_node_index  (in_node_index),
    .in_left_child  (in_left_child),
    .in_right_child (in_right_child),
    .in_is_leaf     (in_is_leaf),
    .in_leaf_symbol (in_leaf_symbol),
    .in_code_byte   (in_code_byte),
    .in_valid_bits  (in_valid_bits),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_symbol     (out_symbol),
    .out_last       (out_last),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench for the prefix tree bit decoder: tree loads, decode walks and symbol checks
`timescale 1ns / 1ps
module testbench;
  import ptbd_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int NODES = NODE_COUNT_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int ROUND_ITEMS = 35;
  localparam int ROUNDS = 8;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic             leaf;
    logic [SYM_W-1:0] symbol;
  } tree_node_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [IDX_W-1:0]   node_index;
    logic [IDX_W-1:0]   left_child;
    logic [IDX_W-1:0]   right_child;
    logic               is_leaf;
    logic [SYM_W-1:0]   leaf_symbol;
    logic [CODE_W-1:0]  code_byte;
    logic [NBITS_W-1:0] valid_bits;
  } tree_request_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } decoded_symbol_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [IDX_W-1:0]    cfg_wr_data;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          in_opcode;
  logic [IDX_W-1:0]    in_node_index;
  logic [IDX_W-1:0]    in_left_child;
  logic [IDX_W-1:0]    in_right_child;
  logic                in_is_leaf;
  logic [SYM_W-1:0]    in_leaf_symbol;
  logic [CODE_W-1:0]   in_code_byte;
  logic [NBITS_W-1:0]  in_valid_bits;
  logic                out_valid;
  logic                out_ready;
  logic [SYM_W-1:0]    out_symbol;
  logic                out_last;

  // Mirror of the node table, the root register and the walk position
  tree_node_t        node_mirror [NODES];
  bit                node_loaded [NODES];
  int                loaded_nodes [$];
  logic [IDX_W-1:0]  root_mirror = '0;
  logic [IDX_W-1:0]  walk_mirror = '0;
  decoded_symbol_t   pending_symbols [$];

  int errors = 0;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  prefix_tree_bit_decoder_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_node_index  (in_node_index),
    .in_left_child  (in_left_child),
    .in_right_child (in_right_child),
    .in_is_leaf     (in_is_leaf),
    .in_leaf_symbol (in_leaf_symbol),
    .in_code_byte   (in_code_byte),
    .in_valid_bits  (in_valid_bits),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_symbol     (out_symbol),
    .out_last       (out_last)
  );

  // Generate the clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each delivered symbol with the oldest expected one
  always @(posedge clk) begin
    decoded_symbol_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_symbols.size() == 0) begin
        $error("out_symbol: no symbol expected, got %0h (out_last %0b)", out_symbol, out_last);
        errors++;
      end else begin
        want = pending_symbols.pop_front();
        if (out_symbol !== want.symbol) begin
          $error("out_symbol: expected %0h, got %0h", want.symbol, out_symbol);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %0b, got %0b", want.last, out_last);
          errors++;
        end
      end
    end
  end

  // Apply one accepted request to the mirror and queue the symbols it decodes
  function automatic void walk_tree(tree_request_t req);
    decoded_symbol_t  found [CODE_W];
    tree_node_t       here;
    logic [IDX_W-1:0] next;
    int               count;
    int               nbits;
    count = 0;
    case (req.opcode)
      OP_WRITE: begin
        node_mirror[req.node_index] = {req.left_child, req.right_child, req.is_leaf,
                                       req.leaf_symbol};
        if (!node_loaded[req.node_index]) begin
          node_loaded[req.node_index] = 1'b1;
          loaded_nodes.push_back(int'(req.node_index));
        end
      end
      OP_DECODE: begin
        // saturate the bit count, then step once per bit, MSB first
        nbits = (req.valid_bits > CODE_W) ? CODE_W : int'(req.valid_bits);
        for (int i = 0; i < nbits; i++) begin
          here = node_mirror[walk_mirror];
          next = req.code_byte[CODE_W - 1 - i] ? here.right : here.left;
          walk_mirror = next;
          if (node_mirror[next].leaf) begin
            found[count] = {node_mirror[next].symbol, 1'b0};
            count++;
            walk_mirror = root_mirror;
          end
        end
        for (int i = 0; i < count; i++)
          pending_symbols.push_back({found[i].symbol, 1'(i == count - 1)});
      end
      OP_RESTART: walk_mirror = root_mirror;
      default: ;
    endcase
  endfunction

  function automatic tree_request_t random_fields();
    tree_request_t req;
    req.opcode      = 2'($urandom_range(3));
    req.node_index  = IDX_W'($urandom_range(NODES - 1));
    req.left_child  = IDX_W'($urandom_range(NODES - 1));
    req.right_child = IDX_W'($urandom_range(NODES - 1));
    req.is_leaf     = 1'($urandom_range(1));
    req.leaf_symbol = SYM_W'($urandom_range(255));
    req.code_byte   = CODE_W'($urandom_range(255));
    req.valid_bits  = NBITS_W'($urandom_range(15));
    return req;
  endfunction

  // Any node already in the table; such children keep every reachable entry loaded
  function automatic int pick_loaded();
    return loaded_nodes[$urandom_range(loaded_nodes.size() - 1)];
  endfunction

  // Present one request, hold it until accepted, then predict it
  task automatic send_request(tree_request_t req);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid       <= 1'b1;
    in_opcode      <= req.opcode;
    in_node_index  <= req.node_index;
    in_left_child  <= req.left_child;
    in_right_child <= req.right_child;
    in_is_leaf     <= req.is_leaf;
    in_leaf_symbol <= req.leaf_symbol;
    in_code_byte   <= req.code_byte;
    in_valid_bits  <= req.valid_bits;
    do @(posedge clk); while (!in_ready);
    walk_tree(req);
  endtask

  task automatic load_node(int idx, int left, int right, bit leaf, int sym);
    tree_request_t req;
    req = random_fields();
    req.opcode      = OP_WRITE;
    req.node_index  = IDX_W'(idx);
    req.left_child  = IDX_W'(left);
    req.right_child = IDX_W'(right);
    req.is_leaf     = leaf;
    req.leaf_symbol = SYM_W'(sym);
    send_request(req);
  endtask

  task automatic send_code(logic [CODE_W-1:0] code, logic [NBITS_W-1:0] nbits);
    tree_request_t req;
    req = random_fields();
    req.opcode     = OP_DECODE;
    req.code_byte  = code;
    req.valid_bits = nbits;
    send_request(req);
  endtask

  task automatic send_restart();
    tree_request_t req;
    req = random_fields();
    req.opcode = OP_RESTART;
    send_request(req);
  endtask

  // Drop valid, wait for every expected symbol, then let the block settle
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_root(int idx);
    drain_block();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= IDX_W'(idx);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    root_mirror = IDX_W'(idx);
  endtask

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin idle_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin idle_pct = 55; stall_pct = 0;  end
      IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 55; end
      default:       begin idle_pct = 33; stall_pct = 33; end
    endcase
  endtask

  // Load a proper prefix tree: leaves first, then merge random pairs up to root_idx
  task automatic build_code_tree(int root_idx, int leaf_count);
    int pool [$];
    bit taken [NODES];
    int a;
    int b;
    int idx;
    int pick;
    int sym;
    taken[root_idx] = 1'b1;
    for (int k = 0; k < leaf_count; k++) begin
      do idx = $urandom_range(NODES - 1); while (taken[idx]);
      taken[idx] = 1'b1;
      sym = (k == 0) ? 0 : (k == 1) ? 255 : $urandom_range(255);
      load_node(idx, idx, (loaded_nodes.size() != 0) ? pick_loaded() : idx, 1'b1, sym);
      pool.push_back(idx);
    end
    while (pool.size() > 1) begin
      pick = $urandom_range(pool.size() - 1);
      a = pool[pick];
      pool.delete(pick);
      pick = $urandom_range(pool.size() - 1);
      b = pool[pick];
      pool.delete(pick);
      if (pool.size() == 0) begin
        idx = root_idx;
      end else begin
        do idx = $urandom_range(NODES - 1); while (taken[idx]);
        taken[idx] = 1'b1;
      end
      load_node(idx, a, b, 1'b0, $urandom_range(255));
      pool.push_back(idx);
    end
  endtask

  // Decode from the walk position left by reset, with root 0, bit count extremes
  task automatic test_reset_walk();
    tree_request_t req;
    set_idling(IDLE_NONE);
    load_node(NODES - 1, NODES - 1, NODES - 1, 1'b1, 255);
    load_node(1, 1, 1, 1'b1, 0);
    load_node(0, 1, NODES - 1, 1'b0, $urandom_range(255));
    send_code(8'hA5, 4'd8);
    send_code(8'h00, 4'd0);
    send_code(8'hFF, 4'd15);
    send_code(8'h80, 4'd1);
    req = random_fields();
    req.opcode = OP_UNUSED;
    send_request(req);
    send_restart();
  endtask

  // A root marked as a leaf is still left through its stored children
  task automatic test_leaf_root();
    load_node(2, 0, NODES - 1, 1'b1, $urandom_range(255));
    set_root(2);
    send_restart();
    send_code(8'h4B, 4'd8);
  endtask

  // A root change leaves the walk in place; the new root applies after the next leaf
  task automatic test_root_change();
    load_node(3, 1, NODES - 1, 1'b0, $urandom_range(255));
    load_node(0, 3, NODES - 1, 1'b0, $urandom_range(255));
    set_root(0);
    send_restart();
    send_code(8'h00, 4'd1);
    set_root(2);
    send_code(8'hB7, 4'd8);
  endtask

  // Rewrite the node the walk stands on; the next step sees the new children
  task automatic test_write_during_walk();
    send_restart();
    send_code(8'h00, 4'd1);
    load_node(0, 1, 3, 1'b0, $urandom_range(255));
    send_code(8'h00, 4'd3);
  endtask

  // Fresh trees under each idling mode, mostly decodes plus restarts and noise
  task automatic test_random_streams();
    tree_request_t req;
    int root_idx;
    int roll;
    for (int r = 0; r < ROUNDS; r++) begin
      set_idling(idle_mode_t'(r % 4));
      root_idx = (r == 0) ? NODES - 1 : (r == 1) ? 0 : $urandom_range(NODES - 1);
      build_code_tree(root_idx, $urandom_range(3, 24));
      set_root(root_idx);
      send_restart();
      repeat (ROUND_ITEMS) begin
        roll = $urandom_range(99);
        req = random_fields();
        if (roll < 68) begin
          req.opcode = OP_DECODE;
          req.valid_bits = NBITS_W'($urandom_range(1, CODE_W));
        end else if (roll < 73) begin
          req.opcode = OP_DECODE;
          req.valid_bits = '0;
        end else if (roll < 78) begin
          req.opcode = OP_DECODE;
          req.valid_bits = NBITS_W'($urandom_range(CODE_W + 1, 15));
        end else if (roll < 84) begin
          req.opcode = OP_RESTART;
        end else if (roll < 89) begin
          req.opcode = OP_UNUSED;
        end else begin
          // overwrite any entry, children taken from loaded nodes
          req.opcode = OP_WRITE;
          req.left_child = IDX_W'(pick_loaded());
          req.right_child = IDX_W'(pick_loaded());
        end
        send_request(req);
      end
      drain_block();
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    in_valid       <= 1'b0;
    in_opcode      <= OP_WRITE;
    in_node_index  <= '0;
    in_left_child  <= '0;
    in_right_child <= '0;
    in_is_leaf     <= 1'b0;
    in_leaf_symbol <= '0;
    in_code_byte   <= '0;
    in_valid_bits  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_walk();
    test_leaf_root();
    test_root_change();
    test_write_during_walk();
    test_random_streams();
    drain_block();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/ptbd_pkg.sv
rtl/ptbd_ctrl.sv
rtl/ptbd_datapath.sv
rtl/prefix_tree_bit_decoder_core.sv
tb/sv/testbench.sv
